// ----- rtl/babylonian_square_root_unit_macros.svh -----
// Assertion macros for the square root unit.
// Assertions sample on clk; rst is the synchronous reset in scope.
`ifndef BABYLONIAN_SQUARE_ROOT_UNIT_MACROS_SVH
`define BABYLONIAN_SQUARE_ROOT_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// checked outside reset
`define BSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define BSR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BSR_ASSERT(lbl, prop, msg)
`define BSR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/bsr_pkg.sv -----
// Shared widths, codes, types and the microcode table of the square root unit.
// No dependencies.
package bsr_pkg;

  localparam int VALUE_W  = 32;
  localparam int FRAC_W   = 16;
  localparam int N_W      = VALUE_W - 1;        // magnitude of a positive operand
  localparam int NUM_W    = N_W + FRAC_W;       // dividend value * 2^16
  localparam int GUESS_W  = NUM_W + 1;
  localparam int TOL_W    = 16;
  localparam int LIM_W    = 16;
  localparam int STEPS_W  = 16;
  localparam int PROD_W   = GUESS_W + TOL_W;
  localparam int ROOT_W   = 31;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = $clog2(NUM_W + 1);
  localparam int CFG_IDX_W = 1;
  localparam int STEP_W   = 3;
  localparam int OP_W     = 3;
  localparam int COND_W   = 3;

  localparam logic [GUESS_W-1:0] ONE_FIXED = GUESS_W'(1) << FRAC_W;
  localparam logic [ROOT_W-1:0]  ROOT_MAX  = '1;
  localparam logic [TOL_W-1:0]   TOL_RESET = 16'd655;
  localparam logic [LIM_W-1:0]   LIM_RESET = 16'd10000;

  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LIMIT   = 2'd2;

  localparam logic [1:0] KIND_NORMAL = 2'd0;
  localparam logic [1:0] KIND_ZERO   = 2'd1;
  localparam logic [1:0] KIND_NEG    = 2'd2;

  // program steps
  localparam logic [STEP_W-1:0] S_IDLE = 3'd0;
  localparam logic [STEP_W-1:0] S_SEED = 3'd1;
  localparam logic [STEP_W-1:0] S_DIV  = 3'd2;
  localparam logic [STEP_W-1:0] S_AVG  = 3'd3;
  localparam logic [STEP_W-1:0] S_TEST = 3'd4;
  localparam logic [STEP_W-1:0] S_EMIT = 3'd5;

  // datapath operations
  localparam logic [OP_W-1:0] OP_NONE = 3'd0;
  localparam logic [OP_W-1:0] OP_SEED = 3'd1;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd2;
  localparam logic [OP_W-1:0] OP_AVG  = 3'd3;
  localparam logic [OP_W-1:0] OP_EMIT = 3'd4;

  // jump conditions
  localparam logic [COND_W-1:0] COND_NEVER    = 3'd0;
  localparam logic [COND_W-1:0] COND_NO_INPUT = 3'd1;
  localparam logic [COND_W-1:0] COND_SPECIAL  = 3'd2;
  localparam logic [COND_W-1:0] COND_DIV_BUSY = 3'd3;
  localparam logic [COND_W-1:0] COND_GOING    = 3'd4;
  localparam logic [COND_W-1:0] COND_OUT_FULL = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] jump_to;
    logic [STEP_W-1:0] next;
  } uword_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            start;
  } dp_ctrl_t;

  typedef struct packed {
    logic special;
    logic div_busy;
    logic going;
    logic more;
  } dp_flags_t;

  typedef struct packed {
    logic [ROOT_W-1:0]   root;
    logic [STATUS_W-1:0] status;
    logic [STEPS_W-1:0]  steps;
  } result_t;

  function automatic uword_t ucode(input logic [STEP_W-1:0] pc);
    uword_t w;
    case (pc)
      S_IDLE:  w = '{op: OP_NONE, cond: COND_NO_INPUT, jump_to: S_IDLE, next: S_SEED};
      S_SEED:  w = '{op: OP_SEED, cond: COND_SPECIAL,  jump_to: S_EMIT, next: S_DIV};
      S_DIV:   w = '{op: OP_DIV,  cond: COND_DIV_BUSY, jump_to: S_DIV,  next: S_AVG};
      S_AVG:   w = '{op: OP_AVG,  cond: COND_NEVER,    jump_to: S_IDLE, next: S_TEST};
      S_TEST:  w = '{op: OP_NONE, cond: COND_GOING,    jump_to: S_SEED, next: S_EMIT};
      S_EMIT:  w = '{op: OP_EMIT, cond: COND_OUT_FULL, jump_to: S_EMIT, next: S_IDLE};
      default: w = '{op: OP_NONE, cond: COND_NEVER,    jump_to: S_IDLE, next: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/bsr_datapath.sv -----
// Datapath of the square root unit: operand, guess, bit-serial divider,
// averaging, tolerance product and step count. Uses bsr_pkg.
module bsr_datapath (
  input  logic                             clk,
  input  bsr_pkg::dp_ctrl_t                ctrl,
  input  logic [bsr_pkg::VALUE_W-1:0]      value,
  input  logic [bsr_pkg::TOL_W-1:0]        tolerance,
  input  logic [bsr_pkg::LIM_W-1:0]        iteration_limit,
  output bsr_pkg::dp_flags_t               flags,
  output bsr_pkg::result_t                 result
);

  logic [bsr_pkg::N_W-1:0]     n;
  logic [1:0]                  kind;
  logic [bsr_pkg::GUESS_W-1:0] guess;
  logic [bsr_pkg::GUESS_W-1:0] rem;
  logic [bsr_pkg::NUM_W-1:0]   quot;
  logic [bsr_pkg::CNT_W-1:0]   cnt;
  logic [bsr_pkg::GUESS_W-1:0] diff;
  logic [bsr_pkg::PROD_W-1:0]  prod;
  logic [bsr_pkg::STEPS_W-1:0] steps;

  logic [bsr_pkg::GUESS_W-1:0] guess_fixed;
  logic [bsr_pkg::GUESS_W:0]   shifted;
  logic [bsr_pkg::GUESS_W+1:0] trial;
  logic                        fits;
  logic [bsr_pkg::GUESS_W-1:0] r_ext;
  logic [bsr_pkg::GUESS_W-1:0] avg;
  logic [bsr_pkg::GUESS_W-1:0] thr;

  always_comb begin
    guess_fixed = (guess == '0) ? bsr_pkg::ONE_FIXED : guess;
    // restoring division, one quotient bit per beat of OP_DIV
    shifted = {rem, quot[bsr_pkg::NUM_W-1]};
    trial   = {1'b0, shifted} - {2'b00, guess};
    fits    = !trial[bsr_pkg::GUESS_W+1];
    r_ext   = bsr_pkg::GUESS_W'(quot);
    avg     = (guess >> 1) + (r_ext >> 1)
            + bsr_pkg::GUESS_W'(guess[0] & r_ext[0]);
    thr     = prod[bsr_pkg::PROD_W-1:bsr_pkg::FRAC_W];
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      n     <= value[bsr_pkg::N_W-1:0];
      guess <= bsr_pkg::GUESS_W'(value[bsr_pkg::N_W-1:1]);
      steps <= '0;
      if (value[bsr_pkg::VALUE_W-1]) begin
        kind <= bsr_pkg::KIND_NEG;
      end else if (value == '0) begin
        kind <= bsr_pkg::KIND_ZERO;
      end else begin
        kind <= bsr_pkg::KIND_NORMAL;
      end
    end else begin
      case (ctrl.op)
        bsr_pkg::OP_SEED: begin
          guess <= guess_fixed;
          rem   <= '0;
          quot  <= {n, bsr_pkg::FRAC_W'(0)};
          cnt   <= bsr_pkg::CNT_W'(bsr_pkg::NUM_W);
        end
        bsr_pkg::OP_DIV: begin
          rem  <= fits ? trial[bsr_pkg::GUESS_W-1:0] : shifted[bsr_pkg::GUESS_W-1:0];
          quot <= {quot[bsr_pkg::NUM_W-2:0], fits};
          cnt  <= cnt - 1'b1;
        end
        bsr_pkg::OP_AVG: begin
          guess <= avg;
          diff  <= (avg > guess) ? avg - guess : guess - avg;
          prod  <= bsr_pkg::PROD_W'(guess) * bsr_pkg::PROD_W'(tolerance);
          steps <= steps + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    flags.special  = (kind != bsr_pkg::KIND_NORMAL);
    flags.div_busy = (cnt != bsr_pkg::CNT_W'(1));
    flags.going    = (diff > thr);
    flags.more     = (steps < iteration_limit);

    if (kind != bsr_pkg::KIND_NORMAL) begin
      result.root = '0;
    end else if (guess > bsr_pkg::GUESS_W'(bsr_pkg::ROOT_MAX)) begin
      result.root = bsr_pkg::ROOT_MAX;
    end else begin
      result.root = guess[bsr_pkg::ROOT_W-1:0];
    end

    if (kind == bsr_pkg::KIND_NEG) begin
      result.status = bsr_pkg::ST_INVALID;
    end else if (kind == bsr_pkg::KIND_NORMAL && flags.going) begin
      result.status = bsr_pkg::ST_LIMIT;
    end else begin
      result.status = bsr_pkg::ST_OK;
    end
    result.steps = steps;
  end

endmodule

// ----- rtl/babylonian_square_root_unit.sv -----
// Top level: microcode sequencer, config registers, output stage. Uses bsr_pkg,
// bsr_datapath and the assertion macro header.
// Each Newton step runs seed, the divider cycles (one quotient bit each), average and
// test; test loops back to seed while the guess still moves and the limit allows.
// Zero and negative inputs go from seed straight to emit. One item at a time, next beat
// taken the cycle after the result loads. Reset: sync, rst high.
`include "babylonian_square_root_unit_macros.svh"

module babylonian_square_root_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bsr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                       cfg_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [31:0]                       s_axis_tdata,   // [31:0] value
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [47:0]                       m_axis_tdata,   // [30:0] root, [46:31] steps_taken, [47] zero
  output logic [1:0]                        m_axis_tuser    // [1:0] status
);

  logic [bsr_pkg::STEP_W-1:0]   pc;
  logic [bsr_pkg::STEP_W-1:0]   pc_next;
  logic [bsr_pkg::TOL_W-1:0]    tolerance;
  logic [bsr_pkg::LIM_W-1:0]    iteration_limit;
  logic                         out_valid;
  logic [bsr_pkg::ROOT_W-1:0]   out_root;
  logic [bsr_pkg::STATUS_W-1:0] out_status;
  logic [bsr_pkg::STEPS_W-1:0]  out_steps;

  bsr_pkg::uword_t   uw;
  bsr_pkg::dp_ctrl_t ctrl;
  bsr_pkg::dp_flags_t flags;
  bsr_pkg::result_t  res;
  logic              accept;
  logic              out_full;
  logic              out_load;
  logic              taken;

  assign s_axis_tready = (pc == bsr_pkg::S_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign out_full      = out_valid & ~m_axis_tready;

  always_comb begin
    uw         = bsr_pkg::ucode(pc);
    ctrl.op    = uw.op;
    ctrl.start = accept;
    out_load   = (uw.op == bsr_pkg::OP_EMIT) && !out_full;
    case (uw.cond)
      bsr_pkg::COND_NEVER:    taken = 1'b0;
      bsr_pkg::COND_NO_INPUT: taken = !s_axis_tvalid;
      bsr_pkg::COND_SPECIAL:  taken = flags.special;
      bsr_pkg::COND_DIV_BUSY: taken = flags.div_busy;
      bsr_pkg::COND_GOING:    taken = flags.going && flags.more;
      bsr_pkg::COND_OUT_FULL: taken = out_full;
      default:                taken = 1'b0;
    endcase
    pc_next = taken ? uw.jump_to : uw.next;
  end

  bsr_datapath u_datapath (
    .clk             (clk),
    .ctrl            (ctrl),
    .value           (s_axis_tdata),
    .tolerance       (tolerance),
    .iteration_limit (iteration_limit),
    .flags           (flags),
    .result          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc              <= bsr_pkg::S_IDLE;
      tolerance       <= bsr_pkg::TOL_RESET;
      iteration_limit <= bsr_pkg::LIM_RESET;
      out_valid       <= 1'b0;
    end else begin
      pc <= pc_next;
      if (cfg_we) begin
        case (cfg_index)
          bsr_pkg::CFG_TOLERANCE: tolerance       <= cfg_data[bsr_pkg::TOL_W-1:0];
          bsr_pkg::CFG_LIMIT:     iteration_limit <= cfg_data[bsr_pkg::LIM_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_root   <= res.root;
      out_status <= res.status;
      out_steps  <= res.steps;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_steps, out_root};
  assign m_axis_tuser  = out_status;

  `BSR_ASSERT_ALWAYS(a_reset_empties_output, rst |=> !out_valid, "output valid after reset")
  `BSR_ASSERT(a_accept_starts_seed, accept |=> pc == bsr_pkg::S_SEED, "accepted beat did not start the program")
  `BSR_ASSERT(a_valid_from_emit, $rose(out_valid) |-> $past(pc) == bsr_pkg::S_EMIT, "result appeared outside the emit step")
  `BSR_ASSERT(a_stall_holds_emit, (pc == bsr_pkg::S_EMIT) && out_full |=> pc == bsr_pkg::S_EMIT, "emit step left while output stalled")
  `BSR_ASSERT(a_invalid_is_empty, out_load && (res.status == bsr_pkg::ST_INVALID) |-> (res.steps == '0) && (res.root == '0), "invalid result carries data")

endmodule

// ----- sim/babylonian_square_root_unit_test.sv -----
// Self-checking testbench for babylonian_square_root_unit: Q16.16 Newton square roots.
// Predicts every result in a local fixed-point model and compares each output beat.
// Depends on bsr_pkg and the RTL of the unit.
module babylonian_square_root_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [bsr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]                   cfg_data = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [31:0]                   s_axis_tdata = '0;   // [31:0] value
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [47:0]                   m_axis_tdata;        // [30:0] root, [46:31] steps_taken, [47] zero
  logic [1:0]                    m_axis_tuser;        // [1:0] status

  babylonian_square_root_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the register file
  logic [15:0] tol_model = bsr_pkg::TOL_RESET;
  logic [15:0] limit_model = bsr_pkg::LIM_RESET;

  bsr_pkg::result_t pending_roots [$];
  int               mismatch_count = 0;
  bit               idle_on = 1'b1;
  int               stall_request = 0;
  logic [31:0]      corner_values [$];

  function automatic bsr_pkg::result_t predict_root(input logic [31:0] value);
    bsr_pkg::result_t res;
    logic [63:0]      n, guess, prev, quot, diff, thr;
    int unsigned      count;
    bit               going;
    res = '0;
    if (value[31]) begin
      res.status = bsr_pkg::ST_INVALID;
      return res;
    end
    if (value == 32'd0) begin
      res.status = bsr_pkg::ST_OK;
      return res;
    end
    n = {32'd0, value};
    guess = n >> 1;
    count = 0;
    do begin
      if (guess == 64'd0)
        guess = 64'd1 << bsr_pkg::FRAC_W;
      if ((n / guess) >= (64'd1 << 48))
        quot = '1;
      else
        quot = (n << bsr_pkg::FRAC_W) / guess;
      prev = guess;
      guess = (guess >> 1) + (quot >> 1) + (guess & quot & 64'd1);
      count++;
      diff = (guess > prev) ? guess - prev : prev - guess;
      thr = (prev >> bsr_pkg::FRAC_W) * 64'(tol_model)
          + (((prev & 64'hFFFF) * 64'(tol_model)) >> bsr_pkg::FRAC_W);
      going = diff > thr;
    end while (going && count < limit_model);
    res.root = (guess > 64'(bsr_pkg::ROOT_MAX)) ? bsr_pkg::ROOT_MAX
                                                 : guess[bsr_pkg::ROOT_W-1:0];
    res.status = going ? bsr_pkg::ST_LIMIT : bsr_pkg::ST_OK;
    res.steps = 16'(count);
    return res;
  endfunction

  function automatic logic [31:0] random_operand();
    int unsigned pick;
    logic [31:0] raw;
    logic [63:0] m;
    pick = $urandom_range(0, 99);
    raw = $urandom;
    if (pick < 12)
      return raw | 32'h8000_0000;
    if (pick < 15)
      return 32'd0;
    if (pick < 30)
      return 32'($urandom_range(1, 255));
    if (pick < 85)
      return {1'b0, raw[30:0]} >> $urandom_range(0, 30);
    // exact squares in Q16.16
    m = 64'($urandom_range(1, 32'h007F_FFFF));
    return 32'((m * m) >> bsr_pkg::FRAC_W);
  endfunction

  // entered and left at a falling edge; tvalid stays up for a back-to-back beat
  task automatic send_value(input logic [31:0] value);
    int gap;
    gap = idle_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= value;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_roots.push_back(predict_root(value));
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_roots.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic set_config(input logic [15:0] tol, input logic [15:0] lim);
    cfg_we <= 1'b1;
    cfg_index <= bsr_pkg::CFG_TOLERANCE;
    cfg_data <= tol;
    @(negedge clk);
    cfg_index <= bsr_pkg::CFG_LIMIT;
    cfg_data <= lim;
    @(negedge clk);
    cfg_we <= 1'b0;
    tol_model = tol;
    limit_model = lim;
  endtask

  task automatic send_corners();
    foreach (corner_values[k]) send_value(corner_values[k]);
  endtask

  task automatic test_reset_defaults();
    idle_on = 1'b1;
    send_corners();
    drain();
  endtask

  // with no tolerance only a fixed point stops; keep the limit short
  task automatic test_zero_tolerance();
    set_config(16'd0, 16'd24);
    send_corners();
    drain();
  endtask

  task automatic test_zero_limit();
    set_config(bsr_pkg::TOL_RESET, 16'd0);
    send_corners();
    drain();
  endtask

  task automatic test_loose_tolerance();
    set_config(16'hFFFF, 16'd1);
    send_corners();
    drain();
    set_config(16'hFFFF, 16'hFFFF);
    send_corners();
    drain();
  endtask

  // sink holds off while the source keeps offering, so the unit backs up
  task automatic test_output_stall();
    int i;
    set_config(16'd3000, 16'd40);
    idle_on = 1'b0;
    stall_request = 2000;
    for (i = 0; i < 8; i++) send_value(random_operand() >> 1);
    drain();
    idle_on = 1'b1;
  endtask

  task automatic test_random_settings();
    int          phase, i;
    logic [15:0] tol, lim;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          tol = 16'($urandom_range(1, 65535));
          lim = 16'($urandom_range(8, 40));
        end
        1: begin
          tol = 16'd1;
          lim = 16'd30;
        end
        2: begin
          tol = 16'hFFFF;
          lim = 16'hFFFF;
        end
        3: begin
          tol = bsr_pkg::TOL_RESET;
          lim = bsr_pkg::LIM_RESET;
        end
        4: begin
          tol = 16'($urandom_range(0, 15));
          lim = 16'($urandom_range(1, 20));
        end
        default: begin
          tol = 16'($urandom_range(1, 65535));
          lim = 16'($urandom_range(1, 4));
        end
      endcase
      set_config(tol, lim);
      for (i = 0; i < 85; i++) begin
        idle_on = ((i / 25) % 4) != 3;
        send_value(random_operand());
      end
      drain();
    end
    idle_on = 1'b1;
  endtask

  initial begin : result_sink
    int pause;
    wait (!rst);
    @(negedge clk);
    forever begin
      pause = idle_on ? $urandom_range(0, 13) : 0;
      if (stall_request > 0) begin
        pause = stall_request;
        stall_request = 0;
      end
      if (pause > 0) begin
        m_axis_tready <= 1'b0;
        repeat (pause) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    bsr_pkg::result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_roots.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected beat: expected none, actual root %h status %0d steps %0d",
                 $time, m_axis_tdata[30:0], m_axis_tuser, m_axis_tdata[46:31]);
      end else begin
        want = pending_roots.pop_front();
        if (m_axis_tdata[30:0] !== want.root || m_axis_tuser !== want.status ||
            m_axis_tdata[46:31] !== want.steps || m_axis_tdata[47] !== 1'b0) begin
          mismatch_count++;
          $display("%0t: expected root %h status %0d steps %0d pad 0, actual %h %0d %0d pad %b",
                   $time, want.root, want.status, want.steps, m_axis_tdata[30:0],
                   m_axis_tuser, m_axis_tdata[46:31], m_axis_tdata[47]);
        end
      end
    end
  end

  initial begin
    #100ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    corner_values = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
                      32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0001_0000,
                      32'h0002_0000, 32'h0004_0000, 32'h0000_8000, 32'h4000_0000,
                      32'h0000_FFFF, 32'h0000_0100, 32'h0100_0000, 32'h5555_AAAA};
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_zero_tolerance();
    test_zero_limit();
    test_loose_tolerance();
    test_output_stall();
    test_random_settings();
    repeat (60) @(negedge clk);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- babylonian_square_root_unit.f -----
+incdir+rtl
rtl/bsr_pkg.sv
rtl/bsr_datapath.sv
rtl/babylonian_square_root_unit.sv
sim/babylonian_square_root_unit_test.sv
